[hdl/doea_pkg.sv]
// Shared types and constants for the Dirac operator entry assembly unit.
// Beat payload structs, function, code, config index and state enums.
// No dependencies.
package doea_pkg;

    localparam int IDX_W  = 6;
    localparam int SLOT_W = 3;
    localparam int VAL_W  = 32;
    localparam int TOL_W  = 17;
    localparam int CNT_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int ONE_Q  = 65536;
    localparam logic [TOL_W-1:0] TOL_RESET = 17'd66;

    typedef struct packed {
        logic [1:0]              func;
        logic [SLOT_W-1:0]       slot;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value_re;
        logic signed [VAL_W-1:0] value_im;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] entry_re;
        logic signed [VAL_W-1:0] entry_im;
    } t_out_item;

    typedef enum logic [1:0] {
        FUNC_WR_MAT   = 2'd0,
        FUNC_WR_GAMMA = 2'd1,
        FUNC_RD_ENTRY = 2'd2,
        FUNC_NOP      = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COUNT_H   = 2'd0,
        CFG_COUNT_L   = 2'd1,
        CFG_TOLERANCE = 2'd2,
        CFG_UNUSED    = 2'd3
    } t_cfg_idx;

    typedef enum logic [2:0] {
        CODE_NONE  = 3'd0,
        CODE_POS1  = 3'd1,
        CODE_NEG1  = 3'd2,
        CODE_POS_I = 3'd3,
        CODE_NEG_I = 3'd4
    } t_code;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DECODE,
        ST_SLOT,
        ST_TERM1,
        ST_TERM2,
        ST_DONE
    } t_state;

    // multiply by -i
    function automatic t_code code_mul_neg_i(input t_code c);
        t_code r;
        unique case (c)
            CODE_POS1:  r = CODE_NEG_I;
            CODE_NEG1:  r = CODE_POS_I;
            CODE_POS_I: r = CODE_POS1;
            CODE_NEG_I: r = CODE_NEG1;
            default:    r = CODE_NONE;
        endcase
        return r;
    endfunction

    // multiply by -1
    function automatic t_code code_negate(input t_code c);
        t_code r;
        unique case (c)
            CODE_POS1:  r = CODE_NEG1;
            CODE_NEG1:  r = CODE_POS1;
            CODE_POS_I: r = CODE_NEG_I;
            CODE_NEG_I: r = CODE_POS_I;
            default:    r = CODE_NONE;
        endcase
        return r;
    endfunction

endpackage

[hdl/dirac_operator_entry_assembly_unit.sv]
// Top level: matrix and gamma code stores, read sequencer and shared accumulator.
// Depends on doea_pkg.
//
// Writes of a matrix or gamma element take one beat. A read of an assembled
// entry steps through decode, then per slot a slot check plus, for an active
// slot, two term steps, then finish; the term steps follow from the single
// read port of the matrix store (two words per slot) feeding one complex
// add/subtract unit. After reset the gamma store is swept to zero, all
// MAX_SLOTS*GAMMA_DIM^2 entries, with input not ready; config writes are
// taken at any time. A finished result sits in an output register, so the
// next item is accepted while it waits.
module dirac_operator_entry_assembly_unit
    import doea_pkg::*;
#(
    parameter int MAT_DIM   = 4,
    parameter int GAMMA_DIM = 4,
    parameter int MAX_SLOTS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [TOL_W-1:0]     i_cfg_data
);

    localparam int SWEEP  = MAT_DIM * MAT_DIM;
    localparam int GSQ    = GAMMA_DIM * GAMMA_DIM;
    localparam int DIRAC  = GAMMA_DIM * SWEEP;
    localparam int MDEPTH = MAX_SLOTS * SWEEP;
    localparam int GDEPTH = MAX_SLOTS * GSQ;
    localparam int MA_W   = $clog2(MDEPTH);
    localparam int GA_W   = (GDEPTH > 1) ? $clog2(GDEPTH) : 1;
    localparam int N_W    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int GB_W   = (GAMMA_DIM > 1) ? $clog2(GAMMA_DIM) : 1;
    localparam int MI_W   = $clog2(MAT_DIM);
    localparam int RI_W   = $clog2(SWEEP);
    localparam int ACC_W  = 34 + $clog2(MAX_SLOTS);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // stores
    logic [2*VAL_W-1:0] mem_mat [MDEPTH];
    logic [2:0]         mem_gam [GDEPTH];

    t_state             r_state, n_state;
    logic [GA_W-1:0]    r_clr, n_clr;
    logic [N_W-1:0]     r_n, n_n;
    logic [CNT_W-1:0]   r_count_h, r_count_l;
    logic [TOL_W-1:0]   r_tol;
    logic               r_out_valid, n_out_valid;
    t_out_item          r_out, n_out;

    logic [IDX_W-1:0]   r_row, n_row, r_col, n_col;
    logic [GA_W-1:0]    r_gofs, n_gofs, r_gslot, n_gslot;
    logic [RI_W-1:0]    r_mofs1, n_mofs1, r_mofs2, n_mofs2;
    logic [MA_W-1:0]    r_mslot, n_mslot;
    logic               r_bq_eq, n_bq_eq, r_ap_eq, n_ap_eq;
    logic               r_is_l, n_is_l;
    logic signed [ACC_W-1:0] r_acc_re, n_acc_re, r_acc_im, n_acc_im;

    logic [2*VAL_W-1:0] r_mat_q;
    logic [2:0]         r_gam_q;

    logic               in_acc, last_slot, slot_act, slot_h, slot_l;
    logic               mat_we, gam_we;
    logic [MA_W-1:0]    mat_waddr, mat_raddr;
    logic [GA_W-1:0]    gam_waddr, gam_raddr;
    logic [2:0]         gam_wdata;

    logic [GB_W-1:0]    bi, bj;
    logic [RI_W-1:0]    ri, ci;
    logic [MI_W-1:0]    da, db, dp, dq;

    logic signed [VAL_W+1:0] tol_s, d_re_p, d_re_m, d_im_p, d_im_m;
    t_code              wr_code;

    t_code              eff_code;
    logic               term_en, sel_swap, neg_re, neg_im;
    logic signed [VAL_W-1:0] w_re, w_im, op_re, op_im;

    assign in_acc      = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // gamma word classification
    always_comb begin
        tol_s  = $signed({{(VAL_W+2-TOL_W){1'b0}}, r_tol});
        d_re_p = (VAL_W+2)'(i_in_data.value_re) - (VAL_W+2)'(ONE_Q);
        d_re_m = (VAL_W+2)'(i_in_data.value_re) + (VAL_W+2)'(ONE_Q);
        d_im_p = (VAL_W+2)'(i_in_data.value_im) - (VAL_W+2)'(ONE_Q);
        d_im_m = (VAL_W+2)'(i_in_data.value_im) + (VAL_W+2)'(ONE_Q);
        priority if (d_re_p < tol_s && d_re_p > -tol_s) wr_code = CODE_POS1;
        else if (d_re_m < tol_s && d_re_m > -tol_s)     wr_code = CODE_NEG1;
        else if (d_im_p < tol_s && d_im_p > -tol_s)     wr_code = CODE_POS_I;
        else if (d_im_m < tol_s && d_im_m > -tol_s)     wr_code = CODE_NEG_I;
        else                                            wr_code = CODE_NONE;
    end

    // index split of the held row and col
    always_comb begin
        bi = '0;
        bj = '0;
        ri = RI_W'(r_row);
        ci = RI_W'(r_col);
        for (int k = 1; k < GAMMA_DIM; k++) begin
            if (int'(r_row) >= k * SWEEP) begin
                bi = GB_W'(k);
                ri = RI_W'(int'(r_row) - k * SWEEP);
            end
            if (int'(r_col) >= k * SWEEP) begin
                bj = GB_W'(k);
                ci = RI_W'(int'(r_col) - k * SWEEP);
            end
        end
        da = '0;
        dp = '0;
        db = MI_W'(ri);
        dq = MI_W'(ci);
        for (int k = 1; k < MAT_DIM; k++) begin
            if (int'(ri) >= k * MAT_DIM) begin
                da = MI_W'(k);
                db = MI_W'(int'(ri) - k * MAT_DIM);
            end
            if (int'(ci) >= k * MAT_DIM) begin
                dp = MI_W'(k);
                dq = MI_W'(int'(ci) - k * MAT_DIM);
            end
        end
    end

    // slot activity
    assign slot_h    = int'(r_n) < int'(r_count_h);
    assign slot_l    = !slot_h && (int'(r_n) < int'(r_count_h) + int'(r_count_l));
    assign slot_act  = slot_h || slot_l;
    assign last_slot = (r_n == N_W'(MAX_SLOTS - 1));

    // shared complex add/subtract unit
    always_comb begin
        eff_code = t_code'(r_gam_q);
        if (r_is_l) begin
            eff_code = code_mul_neg_i(eff_code);
        end
        if (r_is_l && r_state == ST_TERM2) begin
            eff_code = code_negate(eff_code);
        end
        term_en = (eff_code != CODE_NONE) &&
                  ((r_state == ST_TERM1 && r_bq_eq) || (r_state == ST_TERM2 && r_ap_eq));
        sel_swap = (eff_code == CODE_POS_I) || (eff_code == CODE_NEG_I);
        neg_re   = (eff_code == CODE_NEG1) || (eff_code == CODE_POS_I);
        neg_im   = (eff_code == CODE_NEG1) || (eff_code == CODE_NEG_I);
        w_re     = $signed(r_mat_q[VAL_W-1:0]);
        w_im     = $signed(r_mat_q[2*VAL_W-1:VAL_W]);
        op_re    = sel_swap ? w_im : w_re;
        op_im    = sel_swap ? w_re : w_im;
    end

    // read addresses
    assign gam_raddr = r_gslot + r_gofs;
    assign mat_raddr = r_mslot + MA_W'(r_state == ST_TERM1 ? r_mofs2 : r_mofs1);

    // write ports
    always_comb begin
        mat_we    = in_acc && (i_in_data.func == FUNC_WR_MAT) &&
                    int'(i_in_data.slot) < MAX_SLOTS &&
                    int'(i_in_data.row) < MAT_DIM && int'(i_in_data.col) < MAT_DIM;
        mat_waddr = MA_W'(int'(i_in_data.slot) * SWEEP +
                          int'(i_in_data.row) * MAT_DIM + int'(i_in_data.col));
        if (r_state == ST_CLEAR) begin
            gam_we    = 1'b1;
            gam_waddr = r_clr;
            gam_wdata = CODE_NONE;
        end else begin
            gam_we    = in_acc && (i_in_data.func == FUNC_WR_GAMMA) &&
                        int'(i_in_data.slot) < MAX_SLOTS &&
                        int'(i_in_data.row) < GAMMA_DIM && int'(i_in_data.col) < GAMMA_DIM;
            gam_waddr = GA_W'(int'(i_in_data.slot) * GSQ +
                              int'(i_in_data.row) * GAMMA_DIM + int'(i_in_data.col));
            gam_wdata = wr_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mat_we) begin
            mem_mat[mat_waddr] <= {i_in_data.value_im, i_in_data.value_re};
        end
        r_mat_q <= mem_mat[mat_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (gam_we) begin
            mem_gam[gam_waddr] <= gam_wdata;
        end
        r_gam_q <= mem_gam[gam_raddr];
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_n         = r_n;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        n_row       = r_row;
        n_col       = r_col;
        n_gofs      = r_gofs;
        n_gslot     = r_gslot;
        n_mofs1     = r_mofs1;
        n_mofs2     = r_mofs2;
        n_mslot     = r_mslot;
        n_bq_eq     = r_bq_eq;
        n_ap_eq     = r_ap_eq;
        n_is_l      = r_is_l;
        n_acc_re    = r_acc_re;
        n_acc_im    = r_acc_im;

        unique case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + GA_W'(1);
                if (r_clr == GA_W'(GDEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && i_in_data.func == FUNC_RD_ENTRY) begin
                    n_row    = i_in_data.row;
                    n_col    = i_in_data.col;
                    n_acc_re = '0;
                    n_acc_im = '0;
                    n_n      = '0;
                    n_gslot  = '0;
                    n_mslot  = '0;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_gofs  = GA_W'(int'(bi) * GAMMA_DIM + int'(bj));
                n_mofs1 = RI_W'(int'(da) * MAT_DIM + int'(dp));
                n_mofs2 = RI_W'(int'(dq) * MAT_DIM + int'(db));
                n_bq_eq = (db == dq);
                n_ap_eq = (da == dp);
                if (int'(r_row) < DIRAC && int'(r_col) < DIRAC) begin
                    n_state = ST_SLOT;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SLOT: begin
                n_is_l = slot_l;
                if (slot_act) begin
                    n_state = ST_TERM1;
                end else if (last_slot) begin
                    n_state = ST_DONE;
                end else begin
                    n_n     = r_n + N_W'(1);
                    n_gslot = r_gslot + GA_W'(GSQ);
                    n_mslot = r_mslot + MA_W'(SWEEP);
                end
            end
            ST_TERM1, ST_TERM2: begin
                if (term_en) begin
                    n_acc_re = neg_re ? r_acc_re - ACC_W'(op_re) : r_acc_re + ACC_W'(op_re);
                    n_acc_im = neg_im ? r_acc_im - ACC_W'(op_im) : r_acc_im + ACC_W'(op_im);
                end
                if (r_state == ST_TERM1) begin
                    n_state = ST_TERM2;
                end else if (last_slot) begin
                    n_state = ST_DONE;
                end else begin
                    n_n     = r_n + N_W'(1);
                    n_gslot = r_gslot + GA_W'(GSQ);
                    n_mslot = r_mslot + MA_W'(SWEEP);
                    n_state = ST_SLOT;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    priority if (r_acc_re > SAT_HI) n_out.entry_re = SAT_HI[VAL_W-1:0];
                    else if (r_acc_re < SAT_LO)     n_out.entry_re = SAT_LO[VAL_W-1:0];
                    else                            n_out.entry_re = r_acc_re[VAL_W-1:0];
                    priority if (r_acc_im > SAT_HI) n_out.entry_im = SAT_HI[VAL_W-1:0];
                    else if (r_acc_im < SAT_LO)     n_out.entry_im = SAT_LO[VAL_W-1:0];
                    else                            n_out.entry_im = r_acc_im[VAL_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_n         <= '0;
            r_out_valid <= 1'b0;
            r_count_h   <= '0;
            r_count_l   <= '0;
            r_tol       <= TOL_RESET;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_n         <= n_n;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_COUNT_H:   r_count_h <= i_cfg_data[CNT_W-1:0];
                    CFG_COUNT_L:   r_count_l <= i_cfg_data[CNT_W-1:0];
                    CFG_TOLERANCE: r_tol     <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_row    <= n_row;
        r_col    <= n_col;
        r_gofs   <= n_gofs;
        r_gslot  <= n_gslot;
        r_mofs1  <= n_mofs1;
        r_mofs2  <= n_mofs2;
        r_mslot  <= n_mslot;
        r_bq_eq  <= n_bq_eq;
        r_ap_eq  <= n_ap_eq;
        r_is_l   <= n_is_l;
        r_acc_re <= n_acc_re;
        r_acc_im <= n_acc_im;
    end

endmodule

[hdl/doea_chk.sv]
// Port-level checker for the Dirac operator entry assembly unit, with its bind.
// Depends on doea_pkg and dirac_operator_entry_assembly_unit.
module doea_chk
    import doea_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input t_in_item             i_in_data,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_data
);

    logic in_beat;
    assign in_beat = i_in_valid && o_in_ready;

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat dropped or changed while stalled");

    // a read occupies the engine
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in_data.func == FUNC_RD_ENTRY |=> !o_in_ready)
        else $error("input ready right after a read beat");

    // writes and no-ops leave the input ready in the next cycle
    a_write_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat && i_in_data.func != FUNC_RD_ENTRY |=> o_in_ready)
        else $error("input not ready after a write beat");

    // a new result comes only out of a busy read
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result appeared without a read in progress");

endmodule

bind dirac_operator_entry_assembly_unit doea_chk u_doea_chk (.*);
